### rtl/core/jsw_pkg.sv
// ----------------------------------------------------------------------------
// jsw_pkg: shared types and constants for the two-stream window join
// Transaction structs, window sizing and ring index helper.
// ----------------------------------------------------------------------------
package jsw_pkg;

    localparam int STAMP_BITS   = 48;
    localparam int WIDTH_BITS   = 32;
    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(65536);

    typedef struct packed {
        logic                  stream_id;
        logic [STAMP_BITS-1:0] stamp;
    } item_t;

    typedef struct packed {
        logic [STAMP_BITS-1:0] partner_stamp;
        logic [STAMP_BITS-1:0] new_stamp;
        logic                  new_stream;
        logic                  last_pair;
    } pair_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } jsw_q_t;

    // back end status
    typedef struct packed {
        logic              busy;
        logic [FILL_W-1:0] fill_a;
        logic [FILL_W-1:0] fill_b;
    } jsw_stat_t;

    // ring index plus offset, offset below WINDOW_DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                  input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        sum = (FILL_W+1)'(idx) + (FILL_W+1)'(off);
        if (sum >= (FILL_W+1)'(WINDOW_DEPTH))
            sum = sum - (FILL_W+1)'(WINDOW_DEPTH);
        return IDX_W'(sum);
    endfunction

endpackage

### rtl/core/jsw_ram.sv
// ----------------------------------------------------------------------------
// jsw_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module jsw_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

### rtl/core/jsw_front.sv
// ----------------------------------------------------------------------------
// jsw_front: input acceptance and item queue
// Accepts input transactions into a short FIFO drained by the back end.
// ----------------------------------------------------------------------------
module jsw_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  jsw_pkg::item_t item,
    input  logic           pop,
    output jsw_pkg::jsw_q_t q
);
    import jsw_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              do_pop;

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign do_pop     = pop && (count_reg != '0);
    assign q.valid    = (count_reg != '0);
    assign q.item     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                mem_reg[i] <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wr_ptr_reg] <= item;
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/core/jsw_back.sv
// ----------------------------------------------------------------------------
// jsw_back: window eviction, pair emission and append sequencer
// Walks the partner window one entry per step and owns both window RAMs.
// ----------------------------------------------------------------------------
module jsw_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  jsw_pkg::jsw_q_t                q,
    output logic                           pop,
    input  logic                           cfg_wr_en,
    input  logic [jsw_pkg::WIDTH_BITS-1:0] cfg_wr_data,
    output logic                           pair_valid,
    input  logic                           pair_stall,
    output jsw_pkg::pair_t                 pair,
    output jsw_pkg::jsw_stat_t             stat
);
    import jsw_pkg::*;

    typedef enum logic [2:0] {
        IDLE, EV_RD, EV_CMP, EM_RD, EM_WAIT, APPEND
    } state_t;

    state_t                state_reg;
    logic                  sid_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [IDX_W-1:0]      head_reg [2];
    logic [FILL_W-1:0]     fill_reg [2];
    logic [FILL_W-1:0]     k_reg;
    logic [WIDTH_BITS-1:0] width_reg;
    logic                  pair_valid_reg;
    pair_t                 pair_reg;

    logic                  oth;
    logic [IDX_W-1:0]      oth_head;
    logic [FILL_W-1:0]     oth_fill;
    logic [IDX_W-1:0]      own_head;
    logic [FILL_W-1:0]     own_fill;
    logic                  own_full;
    logic [IDX_W-1:0]      app_head;
    logic [FILL_W-1:0]     app_fill;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [STAMP_BITS-1:0] rdata_a;
    logic [STAMP_BITS-1:0] rdata_b;
    logic [STAMP_BITS-1:0] oth_data;
    logic [STAMP_BITS-1:0] diff;
    logic                  stale;
    logic                  last;
    logic                  out_free;
    logic                  emit;

    assign oth      = ~sid_reg;
    assign oth_head = head_reg[oth];
    assign oth_fill = fill_reg[oth];
    assign own_head = head_reg[sid_reg];
    assign own_fill = fill_reg[sid_reg];

    // drop oldest when own window is full
    assign own_full = (own_fill >= FILL_W'(WINDOW_DEPTH));
    assign app_head = own_full ? wrap_add(own_head, FILL_W'(1)) : own_head;
    assign app_fill = own_full ? FILL_W'(WINDOW_DEPTH - 1) : own_fill;
    assign wr_addr  = wrap_add(app_head, app_fill);

    // k stays zero during eviction, so one address path serves both walks
    assign rd_addr  = wrap_add(oth_head, k_reg);
    assign rd_en    = ((state_reg == EV_RD) && (oth_fill != '0)) || (state_reg == EM_RD);
    assign oth_data = sid_reg ? rdata_a : rdata_b;

    // out-of-order stamp counts as zero difference
    assign diff     = stamp_reg - oth_data;
    assign stale    = (stamp_reg > oth_data) && (diff > STAMP_BITS'(width_reg));
    assign last     = ((FILL_W+1)'(k_reg) + 1'b1) == (FILL_W+1)'(oth_fill);
    assign out_free = !pair_valid_reg || !pair_stall;
    assign emit     = (state_reg == EM_WAIT) && out_free;

    assign pop        = (state_reg == IDLE) && q.valid;
    assign pair_valid = pair_valid_reg;
    assign pair       = pair_reg;
    assign stat.busy   = (state_reg != IDLE);
    assign stat.fill_a = fill_reg[0];
    assign stat.fill_b = fill_reg[1];

    jsw_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(STAMP_BITS)) u_store_a (
        .clk   (clk),
        .we    ((state_reg == APPEND) && !sid_reg),
        .waddr (wr_addr),
        .wdata (stamp_reg),
        .re    (rd_en && sid_reg),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    jsw_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(STAMP_BITS)) u_store_b (
        .clk   (clk),
        .we    ((state_reg == APPEND) && sid_reg),
        .waddr (wr_addr),
        .wdata (stamp_reg),
        .re    (rd_en && !sid_reg),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            sid_reg        <= 1'b0;
            stamp_reg      <= '0;
            k_reg          <= '0;
            head_reg[0]    <= '0;
            head_reg[1]    <= '0;
            fill_reg[0]    <= '0;
            fill_reg[1]    <= '0;
            width_reg      <= WIDTH_RESET;
            pair_valid_reg <= 1'b0;
            pair_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                width_reg <= cfg_wr_data;
            if (emit)
                pair_valid_reg <= 1'b1;
            else if (!pair_stall)
                pair_valid_reg <= 1'b0;

            case (state_reg)
                IDLE:
                begin
                    if (q.valid)
                    begin
                        sid_reg   <= q.item.stream_id;
                        stamp_reg <= q.item.stamp;
                        k_reg     <= '0;
                        state_reg <= EV_RD;
                    end
                end
                EV_RD:
                begin
                    state_reg <= (oth_fill == '0) ? APPEND : EV_CMP;
                end
                EV_CMP:
                begin
                    if (stale)
                    begin
                        head_reg[oth] <= wrap_add(oth_head, FILL_W'(1));
                        fill_reg[oth] <= oth_fill - 1'b1;
                        state_reg     <= EV_RD;
                    end
                    else
                        state_reg <= EM_RD;
                end
                EM_RD:
                begin
                    state_reg <= EM_WAIT;
                end
                EM_WAIT:
                begin
                    if (out_free)
                    begin
                        pair_reg.partner_stamp <= oth_data;
                        pair_reg.new_stamp     <= stamp_reg;
                        pair_reg.new_stream    <= sid_reg;
                        pair_reg.last_pair     <= last;
                        k_reg                  <= k_reg + 1'b1;
                        state_reg              <= last ? APPEND : EM_RD;
                    end
                end
                APPEND:
                begin
                    head_reg[sid_reg] <= app_head;
                    fill_reg[sid_reg] <= app_fill + 1'b1;
                    state_reg         <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/two_stream_window_join_top.sv
// ----------------------------------------------------------------------------
// two_stream_window_join_top: sliding-window join of two timestamped streams
// Pairs each new stamp with the other stream's buffered stamps in the window.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item): one stream tag and stamp per
//   transaction, stamps nondecreasing. Items enter a two-deep queue.
//   pair channel (pair_valid/pair_stall/pair): one transaction per buffered
//   partner stamp still inside the window, oldest first, last_pair set on
//   the final one. An item whose partner window is empty yields nothing.
//   cfg_wr_en/cfg_wr_data write window_width; write only while idle.
// Sequence:
//   For each item the sequencer evicts stale partner entries (EV_RD, EV_CMP
//   per entry), then, if the partner window is not empty, emits one pair per
//   entry (EM_RD, EM_WAIT), set by the single registered read port of the
//   partner window RAM (one read-then-use step per entry), then APPEND. The
//   first pair is registered out of EM_WAIT, after IDLE, EV_RD, EV_CMP, EM_RD.
// Reset: windows empty, window_width = 1.0 (65536); RAM contents are left
//   as is and never read before written.
// Stall: a stalled pair holds; the sequencer waits, then the queue fills
//   and item_stall rises.
// ----------------------------------------------------------------------------
module two_stream_window_join_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  jsw_pkg::item_t                 item,
    output logic                           pair_valid,
    input  logic                           pair_stall,
    output jsw_pkg::pair_t                 pair,
    input  logic                           cfg_wr_en,
    input  logic [jsw_pkg::WIDTH_BITS-1:0] cfg_wr_data
);
    import jsw_pkg::*;

    jsw_q_t    q;
    logic      pop;
    jsw_stat_t stat;

    jsw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .pop        (pop),
        .q          (q)
    );

    jsw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q           (q),
        .pop         (pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pair_valid  (pair_valid),
        .pair_stall  (pair_stall),
        .pair        (pair),
        .stat        (stat)
    );

`ifndef NO_ASSERTIONS
    // window occupancy never exceeds the buffer depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.fill_a <= FILL_W'(WINDOW_DEPTH)) && (stat.fill_b <= FILL_W'(WINDOW_DEPTH)))
        else $error("window fill above depth");

    // eviction and append move a fill count by one step at most
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (stat.fill_a == $past(stat.fill_a))
              || (stat.fill_a == $past(stat.fill_a) + 1'b1)
              || (stat.fill_a == $past(stat.fill_a) - 1'b1))
        else $error("fill_a jumped");

    // a non-final pair means the sequencer still has pairs to deliver
    a_more_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall && !pair.last_pair) |-> stat.busy)
        else $error("pair sequence ended without last_pair");

    // the sequencer only pops the queue when an item is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q.valid && !stat.busy))
        else $error("pop without queued item");
`endif

endmodule
